/* hw/rtl/dmc_pkg.sv */
package dmc_pkg;

    localparam int DEF_MAX_COLUMNS = 16;
    localparam int DEF_MAX_ROWS    = 16;

    localparam int COORD_W = 4;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] GRID_COLUMNS_RESET = 5'd9;
    localparam logic [CFG_W-1:0] GRID_ROWS_RESET    = 5'd5;

    // configuration register indexes
    localparam logic REG_GRID_COLUMNS = 1'b0;
    localparam logic REG_GRID_ROWS    = 1'b1;

    // request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // result actions
    localparam logic [1:0] ACT_START     = 2'd0;
    localparam logic [1:0] ACT_CARVE     = 2'd1;
    localparam logic [1:0] ACT_BACKTRACK = 2'd2;
    localparam logic [1:0] ACT_IDLE      = 2'd3;

    // directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef logic [3:0][1:0] t_order;

    localparam t_order BASE_ORDER = {DIR_LEFT, DIR_DOWN, DIR_RIGHT, DIR_UP};

    typedef struct packed {
        logic [0:0] req_type;
        logic [1:0] pick_of_four;
        logic [1:0] pick_of_three;
        logic [0:0] pick_of_two;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         action;
        logic [COORD_W-1:0] from_col;
        logic [COORD_W-1:0] from_row;
        logic [1:0]         carve_dir;
        logic [COORD_W-1:0] to_col;
        logic [COORD_W-1:0] to_row;
        logic [0:0]         maze_done;
    } t_out_item;

    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP,
        STK_INIT
    } t_stk_op;

    typedef struct packed {
        t_stk_op op;
        logic    peek;
    } t_stk_req;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } t_vis_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_TOP,
        S_ROW2,
        S_DECIDE,
        S_FINISH
    } t_state;

    // fisher-yates shuffle of the four directions, swap positions 3, 2, 1
    function automatic t_order shuffle_dirs(logic [1:0] p4, logic [1:0] p3, logic p2);
        t_order     o;
        logic [1:0] t;
        logic [1:0] s3;
        logic [1:0] s2;
        o  = BASE_ORDER;
        t     = o[3];
        o[3]  = o[p4];
        o[p4] = t;
        s3    = (p3 == 2'd3) ? 2'd0 : p3;
        t     = o[2];
        o[2]  = o[s3];
        o[s3] = t;
        s2    = {1'b0, p2};
        t     = o[1];
        o[1]  = o[s2];
        o[s2] = t;
        return o;
    endfunction

endpackage

/* hw/rtl/dmc_visited.sv */
module dmc_visited import dmc_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    localparam int ROW_W      = $clog2(MAX_ROWS)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_vis_req               i_req,
    input  logic [ROW_W-1:0]       i_rd_addr_a,
    input  logic [ROW_W-1:0]       i_rd_addr_b,
    input  logic [ROW_W-1:0]       i_wr_addr,
    input  logic [MAX_COLUMNS-1:0] i_wr_data,
    output logic [MAX_COLUMNS-1:0] o_rd_data_a,
    output logic [MAX_COLUMNS-1:0] o_rd_data_b,
    output logic                   o_clear_busy
);

    // one word per grid row, one bit per column
    localparam logic [MAX_COLUMNS-1:0] SEED_ROW = MAX_COLUMNS'(1);
    localparam logic [ROW_W-1:0]       LAST_ROW = ROW_W'(MAX_ROWS - 1);

    logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
    logic [MAX_COLUMNS-1:0] r_rd_a;
    logic [MAX_COLUMNS-1:0] r_rd_b;
    logic                   r_clr_busy;
    logic [ROW_W-1:0]       r_clr_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b0;
            r_clr_row  <= '0;
        end else if (i_req.clear) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clr_busy) begin
            r_clr_row <= r_clr_row + ROW_W'(1);
            if (r_clr_row == LAST_ROW) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // clearing sweep leaves only the start cell marked
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_row] <= (r_clr_row == '0) ? SEED_ROW : '0;
        end else if (i_req.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_a <= mem[i_rd_addr_a];
            r_rd_b <= mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a  = r_rd_a;
    assign o_rd_data_b  = r_rd_b;
    assign o_clear_busy = r_clr_busy;

endmodule

/* hw/rtl/dmc_stack.sv */
module dmc_stack import dmc_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    localparam int CELL_W     = $clog2(MAX_COLUMNS) + $clog2(MAX_ROWS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_stk_req          i_req,
    input  logic [CELL_W-1:0] i_push_cell,
    output logic [CELL_W-1:0] o_top_cell,
    output logic              o_empty,
    output logic              o_last
);

    localparam int TOTAL  = MAX_COLUMNS * MAX_ROWS;
    localparam int SIDX_W = $clog2(TOTAL);
    localparam int CNT_W  = $clog2(TOTAL + 1);

    logic [CELL_W-1:0] mem [TOTAL];
    logic [CELL_W-1:0] r_top;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  w_top_pos;
    logic              w_has_room;

    assign w_top_pos  = r_count - CNT_W'(1);
    assign w_has_room = (r_count < CNT_W'(TOTAL));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            unique case (i_req.op)
                STK_HOLD: r_count <= r_count;
                STK_PUSH: begin
                    if (w_has_room) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                STK_POP:  r_count <= w_top_pos;
                STK_INIT: r_count <= CNT_W'(1);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.op == STK_PUSH && w_has_room) begin
            mem[r_count[SIDX_W-1:0]] <= i_push_cell;
        end else if (i_req.op == STK_INIT) begin
            mem[SIDX_W'(0)] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.peek) begin
            r_top <= mem[w_top_pos[SIDX_W-1:0]];
        end
    end

    assign o_top_cell = r_top;
    assign o_empty    = (r_count == '0);
    assign o_last     = (r_count == CNT_W'(1));

`ifndef SYNTHESIS
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.op == STK_PUSH && w_has_room) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("push did not grow the stack");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.op == STK_POP) |-> r_count != '0)
        else $error("pop on empty stack");

    a_peek_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.peek |-> r_count != '0)
        else $error("peek on empty stack");
`endif

endmodule

/* hw/rtl/dfs_maze_carver_top.sv */
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+---------------------
// input    | i_in_valid   | o_in_stall   | i_in_data  (t_in_item)
// output   | o_out_valid  | i_out_stall  | o_out_data (t_out_item)
// config   | i_cfg_we     | none         | i_cfg_idx, i_cfg_data
//
// a search step runs accept, stack top read, visited row reads in S_TOP and S_ROW2
// (the row memory has two read ports, three rows are needed), then decide and write
// back; an idle step goes from accept straight to S_FINISH
// a start waits in S_CLEAR for the row-by-row clearing pass of the visited memory
// synchronous active-low reset; no clearing pass after reset, the stack starts empty
// a result waits in the output register under stall; the next item is taken
// meanwhile and holds in its last state until the output register frees
module dfs_maze_carver_top import dmc_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CELL_W = COL_W + ROW_W;
    localparam int CDIM_W = $clog2(MAX_COLUMNS + 1);
    localparam int RDIM_W = $clog2(MAX_ROWS + 1);

    t_state                 r_state;
    t_state                 n_state;
    logic [CFG_W-1:0]       r_grid_columns;
    logic [CFG_W-1:0]       r_grid_rows;
    t_in_item               r_in;
    logic [MAX_COLUMNS-1:0] r_row_cur;
    logic                   r_out_valid;
    t_out_item              r_out_data;
    logic                   n_out_load;
    t_out_item              n_out_data;

    t_stk_req               w_stk_req;
    logic [CELL_W-1:0]      w_push_cell;
    logic [CELL_W-1:0]      w_top;
    logic                   w_stk_empty;
    logic                   w_stk_last;

    t_vis_req               w_vis_req;
    logic [ROW_W-1:0]       w_rd_addr_a;
    logic [ROW_W-1:0]       w_rd_addr_b;
    logic [ROW_W-1:0]       w_wr_addr;
    logic [MAX_COLUMNS-1:0] w_wr_row;
    logic [MAX_COLUMNS-1:0] w_row_dn;
    logic [MAX_COLUMNS-1:0] w_row_up;
    logic                   w_vis_busy;

    logic                   w_accept;
    logic                   w_out_free;
    logic [CDIM_W-1:0]      w_cols;
    logic [RDIM_W-1:0]      w_rows;
    logic [COL_W-1:0]       w_cx;
    logic [ROW_W-1:0]       w_cy;
    logic [CDIM_W-1:0]      w_cx_e;
    logic [RDIM_W-1:0]      w_cy_e;
    logic [RDIM_W-1:0]      w_cy_p1;
    logic [ROW_W-1:0]       w_up_addr;
    logic [ROW_W-1:0]       w_dn_addr;
    logic [CDIM_W-1:0]      w_nx [4];
    logic [RDIM_W-1:0]      w_ny [4];
    logic                   w_ok [4];
    logic [MAX_COLUMNS-1:0] w_row [4];
    logic [3:0]             w_free;
    t_order                 w_order;
    logic                   w_found;
    logic [1:0]             w_dir;

    function automatic logic free_cell(logic ok, logic [CDIM_W-1:0] nx,
                                       logic [RDIM_W-1:0] ny, logic [CDIM_W-1:0] cols,
                                       logic [RDIM_W-1:0] rows,
                                       logic [MAX_COLUMNS-1:0] row);
        logic [MAX_COLUMNS-1:0] shifted;
        shifted = row >> nx;
        return ok && (nx < cols) && (ny < rows) && !shifted[0];
    endfunction

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= GRID_COLUMNS_RESET;
            r_grid_rows    <= GRID_ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GRID_COLUMNS: r_grid_columns <= i_cfg_data;
                REG_GRID_ROWS:    r_grid_rows    <= i_cfg_data;
            endcase
        end
    end

    // zero counts as one, large values saturate
    always_comb begin
        if (r_grid_columns == '0) begin
            w_cols = CDIM_W'(1);
        end else if (32'(r_grid_columns) > 32'(MAX_COLUMNS)) begin
            w_cols = CDIM_W'(MAX_COLUMNS);
        end else begin
            w_cols = CDIM_W'(r_grid_columns);
        end
        if (r_grid_rows == '0) begin
            w_rows = RDIM_W'(1);
        end else if (32'(r_grid_rows) > 32'(MAX_ROWS)) begin
            w_rows = RDIM_W'(MAX_ROWS);
        end else begin
            w_rows = RDIM_W'(r_grid_rows);
        end
    end

    // neighbours of the top cell
    assign w_cx      = w_top[COL_W-1:0];
    assign w_cy      = w_top[CELL_W-1:COL_W];
    assign w_cx_e    = CDIM_W'(w_cx);
    assign w_cy_e    = RDIM_W'(w_cy);
    assign w_cy_p1   = w_cy_e + RDIM_W'(1);
    assign w_up_addr = (w_cy != '0) ? (w_cy - ROW_W'(1)) : w_cy;
    assign w_dn_addr = (w_cy_p1 < RDIM_W'(MAX_ROWS)) ? ROW_W'(w_cy_p1) : w_cy;

    always_comb begin
        w_nx[DIR_UP]    = w_cx_e;
        w_ny[DIR_UP]    = w_cy_e - RDIM_W'(1);
        w_ok[DIR_UP]    = (w_cy != '0);
        w_row[DIR_UP]   = w_row_up;
        w_nx[DIR_RIGHT]  = w_cx_e + CDIM_W'(1);
        w_ny[DIR_RIGHT]  = w_cy_e;
        w_ok[DIR_RIGHT]  = 1'b1;
        w_row[DIR_RIGHT] = r_row_cur;
        w_nx[DIR_DOWN]  = w_cx_e;
        w_ny[DIR_DOWN]  = w_cy_p1;
        w_ok[DIR_DOWN]  = 1'b1;
        w_row[DIR_DOWN] = w_row_dn;
        w_nx[DIR_LEFT]  = w_cx_e - CDIM_W'(1);
        w_ny[DIR_LEFT]  = w_cy_e;
        w_ok[DIR_LEFT]  = (w_cx != '0);
        w_row[DIR_LEFT] = r_row_cur;
    end

    always_comb begin
        w_free[DIR_UP]    = free_cell(w_ok[DIR_UP], w_nx[DIR_UP], w_ny[DIR_UP],
                                      w_cols, w_rows, w_row[DIR_UP]);
        w_free[DIR_RIGHT] = free_cell(w_ok[DIR_RIGHT], w_nx[DIR_RIGHT], w_ny[DIR_RIGHT],
                                      w_cols, w_rows, w_row[DIR_RIGHT]);
        w_free[DIR_DOWN]  = free_cell(w_ok[DIR_DOWN], w_nx[DIR_DOWN], w_ny[DIR_DOWN],
                                      w_cols, w_rows, w_row[DIR_DOWN]);
        w_free[DIR_LEFT]  = free_cell(w_ok[DIR_LEFT], w_nx[DIR_LEFT], w_ny[DIR_LEFT],
                                      w_cols, w_rows, w_row[DIR_LEFT]);
    end

    assign w_order = shuffle_dirs(r_in.pick_of_four, r_in.pick_of_three, r_in.pick_of_two[0]);

    // first free direction in shuffled order
    always_comb begin
        w_found = 1'b1;
        w_dir   = w_order[0];
        if (w_free[w_order[0]]) begin
            w_dir = w_order[0];
        end else if (w_free[w_order[1]]) begin
            w_dir = w_order[1];
        end else if (w_free[w_order[2]]) begin
            w_dir = w_order[2];
        end else if (w_free[w_order[3]]) begin
            w_dir = w_order[3];
        end else begin
            w_found = 1'b0;
        end
    end

    assign w_wr_addr   = ROW_W'(w_ny[w_dir]);
    assign w_wr_row    = w_row[w_dir] | (MAX_COLUMNS'(1) << w_nx[w_dir]);
    assign w_push_cell = {ROW_W'(w_ny[w_dir]), COL_W'(w_nx[w_dir])};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        w_stk_req   = '{op: STK_HOLD, peek: 1'b0};
        w_vis_req   = '0;
        w_rd_addr_a = w_cy;
        w_rd_addr_b = w_up_addr;
        n_out_load  = 1'b0;
        n_out_data  = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (w_accept) begin
                    if (i_in_data.req_type == REQ_START) begin
                        w_vis_req.clear = 1'b1;
                        n_state         = S_CLEAR;
                    end else if (w_stk_empty) begin
                        n_state = S_FINISH;
                    end else begin
                        w_stk_req.peek = 1'b1;
                        n_state        = S_TOP;
                    end
                end
            end
            S_CLEAR: begin
                if (!w_vis_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_TOP: begin
                w_vis_req.rd_en = 1'b1;
                n_state         = S_ROW2;
            end
            S_ROW2: begin
                w_vis_req.rd_en = 1'b1;
                w_rd_addr_a     = w_dn_addr;
                n_state         = S_DECIDE;
            end
            S_DECIDE: begin
                if (w_out_free) begin
                    n_out_load          = 1'b1;
                    n_out_data.from_col = COORD_W'(w_cx);
                    n_out_data.from_row = COORD_W'(w_cy);
                    if (w_found) begin
                        w_vis_req.wr_en      = 1'b1;
                        w_stk_req.op         = STK_PUSH;
                        n_out_data.action    = ACT_CARVE;
                        n_out_data.carve_dir = w_dir;
                        n_out_data.to_col    = COORD_W'(w_nx[w_dir]);
                        n_out_data.to_row    = COORD_W'(w_ny[w_dir]);
                    end else begin
                        w_stk_req.op         = STK_POP;
                        n_out_data.action    = ACT_BACKTRACK;
                        n_out_data.maze_done = w_stk_last;
                    end
                    n_state = S_IDLE;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_out_load = 1'b1;
                    if (r_in.req_type == REQ_START) begin
                        w_stk_req.op      = STK_INIT;
                        n_out_data.action = ACT_START;
                    end else begin
                        n_out_data.action    = ACT_IDLE;
                        n_out_data.maze_done = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
        if (r_state == S_ROW2) begin
            r_row_cur <= w_row_dn;
        end
        if (n_out_load) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    dmc_stack #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_stk_req),
        .i_push_cell (w_push_cell),
        .o_top_cell  (w_top),
        .o_empty     (w_stk_empty),
        .o_last      (w_stk_last)
    );

    // port a carries the current row, then the row below; port b the row above
    dmc_visited #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_visited (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_vis_req),
        .i_rd_addr_a  (w_rd_addr_a),
        .i_rd_addr_b  (w_rd_addr_b),
        .i_wr_addr    (w_wr_addr),
        .i_wr_data    (w_wr_row),
        .o_rd_data_a  (w_row_dn),
        .o_rd_data_b  (w_row_up),
        .o_clear_busy (w_vis_busy)
    );

`ifndef SYNTHESIS
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vis_busy |-> o_in_stall)
        else $error("item taken during clearing pass");

    a_carve_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.action == ACT_CARVE) |->
        ((r_out_data.from_col != r_out_data.to_col) ||
         (r_out_data.from_row != r_out_data.to_row)))
        else $error("carve to the same cell");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_out_data))
        else $error("waiting result overwritten");
`endif

endmodule

/* verif/maze_check_pkg.sv */
`timescale 1ns / 1ps
package maze_check_pkg;
    import dmc_pkg::*;

    localparam int GRID_SPAN = DEF_MAX_COLUMNS;
    localparam int CELLS     = DEF_MAX_COLUMNS * DEF_MAX_ROWS;

    class carve_tracker;
        bit               visited [CELLS];
        logic [7:0]       trail [CELLS];
        int unsigned      depth;
        logic [CFG_W-1:0] columns_reg;
        logic [CFG_W-1:0] rows_reg;
        t_out_item        expected_moves [$];
        int               errors;

        function new();
            columns_reg = GRID_COLUMNS_RESET;
            rows_reg    = GRID_ROWS_RESET;
            depth       = 0;
            errors      = 0;
            foreach (visited[i]) visited[i] = 1'b0;
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] value);
            if (idx == REG_GRID_COLUMNS) begin
                columns_reg = value;
            end else begin
                rows_reg = value;
            end
        endfunction

        // zero acts as one, anything above the grid maximum saturates
        function int fit_dim(int value, int limit);
            if (value < 1) return 1;
            if (value > limit) return limit;
            return value;
        endfunction

        function int pending();
            return expected_moves.size();
        endfunction

        function int unsigned stack_depth();
            return depth;
        endfunction

        function void note_request(t_in_item req);
            t_out_item  move;
            logic [1:0] order [4];
            logic [1:0] tmp;
            int         swap_pos;
            int         pos;
            int         k;
            int         cols;
            int         rows;
            int         cx;
            int         cy;
            int         nx;
            int         ny;
            int         cell_idx;
            bit         carved;
            move = '0;
            cols = fit_dim(columns_reg, DEF_MAX_COLUMNS);
            rows = fit_dim(rows_reg, DEF_MAX_ROWS);
            if (req.req_type == REQ_START) begin
                foreach (visited[i]) visited[i] = 1'b0;
                visited[0] = 1'b1;
                trail[0]   = 8'd0;
                depth      = 1;
                move.action = ACT_START;
            end else if (depth == 0) begin
                move.action    = ACT_IDLE;
                move.maze_done = 1'b1;
            end else begin
                order[0] = DIR_UP;
                order[1] = DIR_RIGHT;
                order[2] = DIR_DOWN;
                order[3] = DIR_LEFT;
                // each of slots 3, 2, 1 trades with a picked slot at or below it
                for (pos = 3; pos >= 1; pos--) begin
                    if (pos == 3) begin
                        swap_pos = req.pick_of_four;
                    end else if (pos == 2) begin
                        swap_pos = req.pick_of_three % 3;
                    end else begin
                        swap_pos = req.pick_of_two;
                    end
                    tmp             = order[pos];
                    order[pos]      = order[swap_pos];
                    order[swap_pos] = tmp;
                end
                cx = trail[depth - 1][3:0];
                cy = trail[depth - 1][7:4];
                move.from_col = COORD_W'(cx);
                move.from_row = COORD_W'(cy);
                carved = 1'b0;
                for (k = 0; k < 4 && !carved; k++) begin
                    nx = cx;
                    ny = cy;
                    case (order[k])
                        DIR_UP:    ny = cy - 1;
                        DIR_RIGHT: nx = cx + 1;
                        DIR_DOWN:  ny = cy + 1;
                        default:   nx = cx - 1;
                    endcase
                    if (nx >= 0 && ny >= 0 && nx < cols && ny < rows) begin
                        cell_idx = ny * GRID_SPAN + nx;
                        if (!visited[cell_idx]) begin
                            visited[cell_idx] = 1'b1;
                            if (depth < CELLS) begin
                                trail[depth] = cell_idx[7:0];
                                depth++;
                            end
                            carved         = 1'b1;
                            move.action    = ACT_CARVE;
                            move.carve_dir = order[k];
                            move.to_col    = COORD_W'(nx);
                            move.to_row    = COORD_W'(ny);
                        end
                    end
                end
                if (!carved) begin
                    depth--;
                    move.action    = ACT_BACKTRACK;
                    move.maze_done = (depth == 0);
                end
            end
            expected_moves.push_back(move);
        endfunction

        function void compare_field(string name, logic [3:0] want, logic [3:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_move(t_out_item got);
            t_out_item want;
            if (expected_moves.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none, got %h",
                         $time, got);
            end else begin
                want = expected_moves.pop_front();
                compare_field("action", want.action, got.action);
                compare_field("from_col", want.from_col, got.from_col);
                compare_field("from_row", want.from_row, got.from_row);
                compare_field("carve_dir", want.carve_dir, got.carve_dir);
                compare_field("to_col", want.to_col, got.to_col);
                compare_field("to_row", want.to_row, got.to_row);
                compare_field("maze_done", want.maze_done, got.maze_done);
            end
        endfunction
    endclass

endpackage

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import dmc_pkg::*;
    import maze_check_pkg::*;

    localparam int          RANDOM_ITEMS = 1700;
    localparam int          HOLD_CYCLES  = 150;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_item         i_in_data;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_item        o_out_data;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    carve_tracker maze_log = new();
    bit           calm = 1'b0;
    bit           hold_request = 1'b0;
    int unsigned  cycle_count = 0;

    logic [CFG_W-1:0] preset_cols [8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd1, 5'd16, 5'd31};
    logic [CFG_W-1:0] preset_rows [8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd1, 5'd16, 5'd1, 5'd4};

    dfs_maze_carver_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            maze_log.check_move(o_out_data);
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item make_req(logic kind, logic [1:0] p4, logic [1:0] p3, logic p2);
        t_in_item req;
        req.req_type      = kind;
        req.pick_of_four  = p4;
        req.pick_of_three = p3;
        req.pick_of_two   = p2;
        return req;
    endfunction

    function automatic t_in_item random_req(logic kind);
        return make_req(kind, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                        1'($urandom_range(0, 1)));
    endfunction

    // receiver: free and stalled stretches, plus one long hold on request
    initial begin : stall_gen
        int n;
        i_out_stall = 1'b0;
        forever begin
            n = calm ? 1 : gap_len() + 1;
            repeat (n) begin
                @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            if (hold_request) begin
                hold_request = 1'b0;
                n = HOLD_CYCLES;
            end else begin
                n = calm ? 0 : gap_len();
            end
            repeat (n) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
        end
    end

    task automatic offer(input t_in_item req);
        int g;
        g = calm ? 0 : gap_len();
        repeat (g) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        maze_log.note_request(req);
    endtask

    // block is idle once every result is back
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (maze_log.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        maze_log.write_reg(idx, value);
    endtask

    initial begin : main_seq
        int phase;
        int sent;
        int phase_items;
        int phase_cap;
        int r;
        logic [CFG_W-1:0] cols_val;
        logic [CFG_W-1:0] rows_val;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_GRID_COLUMNS;
        i_cfg_data = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-stack step, start, all pick extremes, restart mid maze
        offer(make_req(REQ_STEP, 2'd0, 2'd0, 1'b0));
        offer(make_req(REQ_START, 2'd3, 2'd3, 1'b1));
        offer(make_req(REQ_STEP, 2'd3, 2'd3, 1'b1));
        offer(make_req(REQ_STEP, 2'd0, 2'd0, 1'b0));
        offer(make_req(REQ_STEP, 2'd1, 2'd1, 1'b1));
        offer(make_req(REQ_STEP, 2'd2, 2'd2, 1'b0));
        offer(make_req(REQ_STEP, 2'd3, 2'd0, 1'b1));
        offer(make_req(REQ_STEP, 2'd0, 2'd3, 1'b0));
        offer(make_req(REQ_STEP, 2'd2, 2'd1, 1'b1));
        offer(make_req(REQ_STEP, 2'd1, 2'd2, 1'b0));
        offer(make_req(REQ_START, 2'd0, 2'd0, 1'b0));
        offer(make_req(REQ_STEP, 2'd3, 2'd2, 1'b1));
        // single-cell grid, zero width counts as one
        settle();
        write_reg(REG_GRID_COLUMNS, 5'd0);
        write_reg(REG_GRID_ROWS, 5'd1);
        offer(make_req(REQ_START, 2'd1, 2'd1, 1'b1));
        offer(make_req(REQ_STEP, 2'd2, 2'd3, 1'b1));
        offer(make_req(REQ_STEP, 2'd3, 2'd3, 1'b1));
        // oversize registers saturate to the full grid
        settle();
        write_reg(REG_GRID_COLUMNS, 5'd31);
        write_reg(REG_GRID_ROWS, 5'd31);
        offer(make_req(REQ_START, 2'd0, 2'd0, 1'b0));
        offer(make_req(REQ_STEP, 2'd0, 2'd0, 1'b0));
        offer(make_req(REQ_STEP, 2'd3, 2'd3, 1'b1));
        settle();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            if (phase < 8) begin
                cols_val = preset_cols[phase];
                rows_val = preset_rows[phase];
            end else begin
                cols_val = 5'($urandom_range(0, 31));
                rows_val = 5'($urandom_range(0, 31));
                if ($urandom_range(0, 3) != 0) cols_val = 5'($urandom_range(1, 8));
                if ($urandom_range(0, 3) != 0) rows_val = 5'($urandom_range(1, 8));
            end
            write_reg(REG_GRID_COLUMNS, cols_val);
            write_reg(REG_GRID_ROWS, rows_val);
            calm = (phase % 4 == 2);
            // phase 0 leaves a large maze half built; phase 1 shrinks the grid under it
            phase_cap = (phase == 0) ? 300 : $urandom_range(80, 220);
            phase_items = 0;
            if (phase != 1 && (phase == 0 || $urandom_range(0, 3) != 0)) begin
                offer(random_req(REQ_START));
                phase_items++;
            end
            while (phase_items < phase_cap && sent + phase_items < RANDOM_ITEMS) begin
                if (phase == 0 && phase_items == 40) hold_request = 1'b1;
                r = $urandom_range(0, 99);
                if (maze_log.stack_depth() == 0) begin
                    offer(random_req(r < 85 ? REQ_START : REQ_STEP));
                end else begin
                    offer(random_req(r < 3 ? REQ_START : REQ_STEP));
                end
                phase_items++;
            end
            sent += phase_items;
            settle();
            phase++;
        end

        calm = 1'b0;
        while (maze_log.pending() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (maze_log.errors == 0 && maze_log.pending() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
